// File: src/huffman_code_bit_packer_macros.svh
// Assertion macros used by the bit packer checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HCBP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define HCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/hcbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
// No dependencies.
package hcbp_pkg;

  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned IN_CODE_W  = 32;
  localparam int unsigned IN_LEN_W   = 6;
  localparam int unsigned PAD_W      = 3;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 16;

  // Input transaction opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } opcode_e;

  // Work item kind carried through the queue
  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_FLUSH  = 1'b1
  } kind_e;

endpackage

// File: src/hcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hcbp_ram #(
  parameter int unsigned WIDTH = 38,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/hcbp_front.sv
// Front end: accepts input transactions, loads the code table, looks up codes.
// Depends on hcbp_pkg and hcbp_ram.
module hcbp_front
  import hcbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = 32,
  parameter int unsigned SYMBOLS       = 256
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [OPCODE_W-1:0]                    in_opcode_i,
  input  logic [SYM_W-1:0]                       in_symbol_i,
  input  logic [IN_CODE_W-1:0]                   in_code_i,
  input  logic [IN_LEN_W-1:0]                    in_length_i,
  output logic                                   q_valid_o,
  input  logic                                   q_ready_i,
  output kind_e                                  q_kind_o,
  output logic [MAX_CODE_BITS-1:0]               q_code_o,
  output logic [$clog2(MAX_CODE_BITS+1)-1:0]     q_len_o
);

  localparam int unsigned LEN_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned ADDR_W = $clog2(SYMBOLS);
  localparam int unsigned ENT_W  = MAX_CODE_BITS + LEN_W;

  opcode_e                  op;
  logic                     sym_ok;
  logic                     accept;
  logic [LEN_W-1:0]         len_sat;
  logic [MAX_CODE_BITS-1:0] code_mask;
  logic [MAX_CODE_BITS-1:0] code_m;
  logic                     we;
  logic                     re;
  logic [ENT_W-1:0]         rdata;
  logic [LEN_W-1:0]         rd_len;
  logic [LEN_W-1:0]         rd_len_c;
  logic                     s1_valid_d, s1_valid_q;
  kind_e                    s1_kind_d, s1_kind_q;

  assign op     = opcode_e'(in_opcode_i);
  assign sym_ok = {1'b0, in_symbol_i} < (SYM_W + 1)'(SYMBOLS);
  assign accept = in_valid_i && in_ready_o;

  // Stage 1 drains into the queue; input enters when it is empty or drains
  assign in_ready_o = !s1_valid_q || q_ready_i;

  // Load: saturate the length and drop code bits above it
  assign len_sat   = (in_length_i > IN_LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS)
                                                              : in_length_i[LEN_W-1:0];
  assign code_mask = ~({MAX_CODE_BITS{1'b1}} << len_sat);
  assign code_m    = in_code_i[MAX_CODE_BITS-1:0] & code_mask;

  assign we = accept && (op == OP_LOAD) && sym_ok;
  assign re = accept && (op == OP_ENCODE) && sym_ok;

  hcbp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SYMBOLS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (in_symbol_i[ADDR_W-1:0]),
    .wdata_i ({len_sat, code_m}),
    .re_i    (re),
    .raddr_i (in_symbol_i[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  // Stage 1 control: encode of a valid symbol or flush goes on to the queue
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_kind_d  = s1_kind_q;
    if (accept) begin
      case (op)
        OP_ENCODE: begin
          s1_valid_d = sym_ok;
          s1_kind_d  = KIND_ENCODE;
        end
        OP_FLUSH: begin
          s1_valid_d = 1'b1;
          s1_kind_d  = KIND_FLUSH;
        end
        default: begin
          s1_valid_d = 1'b0;
        end
      endcase
    end else if (q_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_kind_q  <= KIND_ENCODE;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_kind_q  <= s1_kind_d;
    end
  end

  // Clamp the looked-up length and left-align the code in its field
  assign rd_len   = rdata[ENT_W-1:MAX_CODE_BITS];
  assign rd_len_c = (rd_len > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS) : rd_len;

  assign q_valid_o = s1_valid_q;
  assign q_kind_o  = s1_kind_q;
  assign q_code_o  = rdata[MAX_CODE_BITS-1:0] << (LEN_W'(MAX_CODE_BITS) - rd_len_c);
  assign q_len_o   = rd_len_c;

endmodule

// File: src/hcbp_fifo.sv
// Small flop-based queue between the front and back ends.
// No dependencies.
module hcbp_fifo #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PTR_W-1:0] wptr_d, wptr_q;
  logic [PTR_W-1:0] rptr_d, rptr_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             push;
  logic             pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = data_q[rptr_q];

  // Pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/hcbp_back.sv
// Back end: appends codes to bit window, emits a byte per unstalled cycle.
// Depends on hcbp_pkg.
module hcbp_back
  import hcbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  output logic                               q_ready_o,
  input  kind_e                              q_kind_i,
  input  logic [MAX_CODE_BITS-1:0]           q_code_i,
  input  logic [$clog2(MAX_CODE_BITS+1)-1:0] q_len_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [BYTE_BITS-1:0]               out_byte_o,
  output logic [PAD_W-1:0]                   out_pad_o,
  output logic                               out_last_o
);

  localparam int unsigned W  = BYTE_BITS + MAX_CODE_BITS;
  localparam int unsigned NW = $clog2(W);

  // Window holds pending bits left-aligned; bits below cnt are zero
  logic [W-1:0]         win_d, win_q;
  logic [NW-1:0]        cnt_d, cnt_q;
  logic [W-1:0]         win_b;
  logic [NW-1:0]        cnt_b;
  logic                 out_free;
  logic                 emit;
  logic                 idle;
  logic                 flush_ok;
  logic                 pop;
  logic                 ov_d, ov_q;
  logic [BYTE_BITS-1:0] obyte_d, obyte_q;
  logic [PAD_W-1:0]     opad_d, opad_q;
  logic                 olast_d, olast_q;

  assign out_free = !ov_q || out_ready_i;
  assign emit     = out_free && (cnt_q >= NW'(BYTE_BITS));

  // State after this cycle's byte, if any, leaves the window
  assign win_b = emit ? (win_q << BYTE_BITS) : win_q;
  assign cnt_b = emit ? (cnt_q - NW'(BYTE_BITS)) : cnt_q;
  assign idle  = (cnt_b < NW'(BYTE_BITS));

  // A flush needs the output slot unless nothing is pending
  assign flush_ok  = !emit && ((cnt_b == '0) || out_free);
  assign q_ready_o = idle && ((q_kind_i == KIND_ENCODE) || flush_ok);
  assign pop       = q_valid_i && q_ready_o;

  // Window update
  always_comb begin
    win_d = win_b;
    cnt_d = cnt_b;
    if (pop) begin
      case (q_kind_i)
        KIND_ENCODE: begin
          win_d = {win_b[W-1:W-BYTE_BITS], {MAX_CODE_BITS{1'b0}}}
                | ({q_code_i, {BYTE_BITS{1'b0}}} >> cnt_b);
          cnt_d = cnt_b + NW'(q_len_i);
        end
        KIND_FLUSH: begin
          win_d = '0;
          cnt_d = '0;
        end
        default: begin
          win_d = win_b;
          cnt_d = cnt_b;
        end
      endcase
    end
  end

  // Output register
  always_comb begin
    ov_d    = ov_q;
    obyte_d = obyte_q;
    opad_d  = opad_q;
    olast_d = olast_q;
    if (emit) begin
      ov_d    = 1'b1;
      obyte_d = win_q[W-1:W-BYTE_BITS];
      opad_d  = '0;
      olast_d = (cnt_b < NW'(BYTE_BITS));
    end else if (pop && (q_kind_i == KIND_FLUSH) && (cnt_b != '0)) begin
      ov_d    = 1'b1;
      obyte_d = win_b[W-1:W-BYTE_BITS];
      opad_d  = PAD_W'(NW'(BYTE_BITS) - cnt_b);
      olast_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      win_q <= win_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q <= obyte_d;
    opad_q  <= opad_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = obyte_q;
  assign out_pad_o   = opad_q;
  assign out_last_o  = olast_q;

endmodule

// File: src/huffman_code_bit_packer.sv
// Top level of the Huffman code bit packer, MSB first.
// Depends on hcbp_pkg, hcbp_front, hcbp_fifo and hcbp_back.
//
// Usage:
//   Input stream (s_axis): tuser carries the opcode (load, encode, flush),
//   tdata the symbol, code value and code length. A load writes one table
//   entry; an encode appends the symbol's code bits to the pending byte;
//   a flush emits the pending partial byte, zero padded in its low bits.
//   Output stream (m_axis): one transaction per byte; tdata carries the
//   byte and the pad count, tlast marks the last byte of an input item.
// Encode path: table read, stage 1, queue, bit window, output register.
// Flow: an encode or flush enters the back end once no full byte is pending
//   after the byte leaving now; a flush also waits while a byte leaves and,
//   with bits pending, for a free output slot. Loads and unused opcodes go
//   no further than the front end.
// Reset: pending bits are cleared; the code table is not cleared and must
//   be loaded before use.
// Stall: a stalled receiver holds the output byte; the 4-entry queue keeps
//   taking items until full; s_axis_tready drops once stage 1 also holds one.
module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = 32,
  parameter int unsigned SYMBOLS       = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [7:0] symbol, [39:8] code_value, [45:40] code_length, [47:46] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] opcode
  input  logic [OPCODE_W-1:0]   s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [7:0] out_byte, [10:8] pad_bits, [15:11] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  localparam int unsigned LEN_W   = $clog2(MAX_CODE_BITS + 1);
  localparam int unsigned Q_W     = 1 + MAX_CODE_BITS + LEN_W;
  localparam int unsigned Q_DEPTH = 4;

  logic                     f_valid;
  logic                     f_ready;
  kind_e                    f_kind;
  logic [MAX_CODE_BITS-1:0] f_code;
  logic [LEN_W-1:0]         f_len;
  logic                     b_valid;
  logic                     b_ready;
  logic [Q_W-1:0]           b_data;
  logic [BYTE_BITS-1:0]     out_byte;
  logic [PAD_W-1:0]         out_pad;

  hcbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .SYMBOLS       (SYMBOLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_opcode_i (s_axis_tuser),
    .in_symbol_i (s_axis_tdata[7:0]),
    .in_code_i   (s_axis_tdata[39:8]),
    .in_length_i (s_axis_tdata[45:40]),
    .q_valid_o   (f_valid),
    .q_ready_i   (f_ready),
    .q_kind_o    (f_kind),
    .q_code_o    (f_code),
    .q_len_o     (f_len)
  );

  hcbp_fifo #(
    .WIDTH (Q_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_kind, f_code, f_len}),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  hcbp_back #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (b_valid),
    .q_ready_o   (b_ready),
    .q_kind_i    (kind_e'(b_data[Q_W-1])),
    .q_code_i    (b_data[Q_W-2:LEN_W]),
    .q_len_i     (b_data[LEN_W-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_pad_o   (out_pad),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - BYTE_BITS - PAD_W){1'b0}}, out_pad, out_byte};

endmodule

// File: src/hcbp_checker.sv
// Port-level checks of the bit packer output stream, bound to the top level.
// Depends on hcbp_pkg and huffman_code_bit_packer_macros.svh.
`include "huffman_code_bit_packer_macros.svh"

module hcbp_checker
  import hcbp_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  // Stalled output transaction holds
  `HCBP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed under stall")

  // Padding only on the final byte of a flush, and its lowest bit is zero
  `HCBP_ASSERT_IMPL(a_pad_last, m_axis_tvalid && (m_axis_tdata[10:8] != 3'd0), m_axis_tlast && (m_axis_tdata[0] == 1'b0), "padded byte not last or pad bits set")

  // A byte with seven pad bits carries a single data bit
  `HCBP_ASSERT_IMPL(a_pad_seven, m_axis_tvalid && (m_axis_tdata[10:8] == 3'd7), m_axis_tdata[6:0] == 7'd0, "pad bits set in seven-pad byte")

  // Filler bits of tdata stay zero
  `HCBP_ASSERT_IMPL(a_fill_zero, m_axis_tvalid, m_axis_tdata[15:11] == 5'd0, "tdata filler bits nonzero")

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (.*);

// File: tb/sv/hcbp_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the Huffman code bit packer: watches both stream channels,
// predicts the packed bytes and compares them. Depends on hcbp_pkg.
module hcbp_scoreboard
  import hcbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [OPCODE_W-1:0]   in_user_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [OUT_DATA_W-1:0] out_data_i,
  input  logic                  out_last_i,
  output int                    mismatches_o,
  output int                    backlog_o,
  output int                    bytes_checked_o
);

  typedef struct {
    logic [BYTE_BITS-1:0] data;
    logic [PAD_W-1:0]     pad;
    logic                 last;
  } packed_byte_t;

  // Model of the code table and of the partial byte
  logic [IN_CODE_W-1:0] code_bits_mem [256];
  logic [IN_LEN_W-1:0]  code_len_mem  [256];
  logic [BYTE_BITS-1:0] pend_bits;
  logic [PAD_W-1:0]     pend_cnt;

  packed_byte_t packed_byte_q[$];

  task automatic flag_mismatch(input string what);
    mismatches_o++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Apply one input transaction to the model and queue the bytes it yields
  task automatic predict_packing(input logic [OPCODE_W-1:0] op,
                                 input logic [SYM_W-1:0] sym,
                                 input logic [IN_CODE_W-1:0] value,
                                 input logic [IN_LEN_W-1:0] len);
    logic [63:0]  acc;
    logic [63:0]  mask;
    int unsigned  cnt;
    int unsigned  clen;
    int unsigned  n;
    int unsigned  nbytes;
    int unsigned  i;
    packed_byte_t b;
    case (op)
      OP_LOAD: begin
        // overlong lengths saturate, bits above the length are dropped
        clen = (len > MAX_CODE_BITS) ? MAX_CODE_BITS : len;
        mask = (64'd1 << clen) - 64'd1;
        code_len_mem[sym]  = clen[IN_LEN_W-1:0];
        code_bits_mem[sym] = value & mask[IN_CODE_W-1:0];
      end
      OP_ENCODE: begin
        cnt  = pend_cnt;
        clen = code_len_mem[sym];
        acc  = (64'(pend_bits) >> (BYTE_BITS - cnt)) << clen;
        acc  = acc | 64'(code_bits_mem[sym]);
        n      = cnt + clen;
        nbytes = n / BYTE_BITS;
        for (i = 0; i < nbytes; i++) begin
          b.data = 8'(acc >> (n - BYTE_BITS * (i + 1)));
          b.pad  = '0;
          b.last = (i == nbytes - 1);
          packed_byte_q.push_back(b);
        end
        n = n % BYTE_BITS;
        mask = (64'd1 << n) - 64'd1;
        pend_bits = 8'((acc & mask) << (BYTE_BITS - n));
        pend_cnt  = 3'(n);
      end
      OP_FLUSH: begin
        // nothing pending means no byte
        if (pend_cnt != 0) begin
          b.data = pend_bits;
          b.pad  = 3'(BYTE_BITS - pend_cnt);
          b.last = 1'b1;
          packed_byte_q.push_back(b);
          pend_bits = '0;
          pend_cnt  = '0;
        end
      end
      default: ;  // unused opcode is ignored
    endcase
  endtask

  // Compare output transactions, then fold in accepted input transactions
  always @(posedge clk_i or negedge rst_ni) begin
    packed_byte_t exp_b;
    if (!rst_ni) begin
      pend_bits = '0;
      pend_cnt  = '0;
      packed_byte_q.delete();
      backlog_o       = 0;
      mismatches_o    = 0;
      bytes_checked_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        bytes_checked_o++;
        if (packed_byte_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected byte %02h pad %0d last %0b",
                                  out_data_i[7:0], out_data_i[10:8], out_last_i));
        end else begin
          exp_b = packed_byte_q.pop_front();
          if (out_data_i[7:0] !== exp_b.data)
            flag_mismatch($sformatf("byte %02h, expected %02h",
                                    out_data_i[7:0], exp_b.data));
          if (out_data_i[10:8] !== exp_b.pad)
            flag_mismatch($sformatf("pad %0d, expected %0d",
                                    out_data_i[10:8], exp_b.pad));
          if (out_last_i !== exp_b.last)
            flag_mismatch($sformatf("tlast %0b, expected %0b",
                                    out_last_i, exp_b.last));
        end
      end
      if (in_valid_i && in_ready_i)
        predict_packing(in_user_i, in_data_i[7:0], in_data_i[39:8], in_data_i[45:40]);
      backlog_o = packed_byte_q.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the bit packer testbench: clock, reset, stimulus and verdict.
// Depends on hcbp_pkg, huffman_code_bit_packer and hcbp_scoreboard.
module tb;
  import hcbp_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 35;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [OPCODE_W-1:0]   s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  int mismatches;
  int backlog;
  int bytes_checked;

  int src_idle_pct;
  int sink_stall_pct;
  int hold_requests;
  int idle_cycles;
  int op_counts [4];

  bit          sym_loaded [256];
  logic [7:0]  loaded_syms [$];

  huffman_code_bit_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  hcbp_scoreboard checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .in_data_i       (s_axis_tdata),
    .in_user_i       (s_axis_tuser),
    .out_valid_i     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_i      (m_axis_tdata),
    .out_last_i      (m_axis_tlast),
    .mismatches_o    (mismatches),
    .backlog_o       (backlog),
    .bytes_checked_o (bytes_checked)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Sink: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int holds_served;
    int k;
    holds_served  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests > holds_served) begin
        holds_served++;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          m_axis_tready <= 1'b0;
          @(negedge clk_i);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d bytes outstanding",
                 IDLE_LIMIT, backlog);
        $display("FAIL huffman_code_bit_packer");
        $finish;
      end
    end
  end

  // Offer one input transaction, with random idle cycles ahead of it
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [7:0] sym,
                           input logic [31:0] value, input logic [5:0] len);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, len, value, sym};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    op_counts[op]++;
    if (op == OP_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    @(negedge clk_i);
  endtask

  // Mostly encodes of loaded symbols, fresh table loads, flushes, a little noise
  task automatic send_random_item();
    int   r;
    int   lr;
    logic [5:0] len;
    r = $urandom_range(99);
    if (r < 20 || loaded_syms.size() == 0) begin
      lr = $urandom_range(99);
      if (lr < 5)       len = 6'd0;
      else if (lr < 12) len = 6'($urandom_range(63, 33));
      else if (lr < 35) len = 6'($urandom_range(32, 17));
      else              len = 6'($urandom_range(16, 1));
      send_item(OP_LOAD, 8'($urandom_range(255)), $urandom, len);
    end else if (r < 78) begin
      send_item(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                $urandom, 6'($urandom));
    end else if (r < 94) begin
      send_item(OP_FLUSH, 8'($urandom), $urandom, 6'($urandom));
    end else begin
      send_item(OP_UNUSED, 8'($urandom), $urandom, 6'($urandom));
    end
  endtask

  initial begin
    int ph;
    int j;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_LOAD;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_requests  = 0;
    for (j = 0; j < 4; j++) op_counts[j] = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: table corner cases, then encodes that hit each packing case
    send_item(OP_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd32);  // longest code
    send_item(OP_LOAD,   8'hFF, 32'h0000_0000, 6'd1);
    send_item(OP_LOAD,   8'h55, 32'h0000_0005, 6'd3);
    send_item(OP_LOAD,   8'hAA, 32'hFFFF_FFFF, 6'd63);  // saturates to 32
    send_item(OP_LOAD,   8'h01, 32'hFFFF_FFF0, 6'd4);   // upper bits dropped
    send_item(OP_LOAD,   8'h02, 32'hABCD_1234, 6'd0);   // empty code
    send_item(OP_LOAD,   8'h03, 32'h0000_00A5, 6'd8);   // exactly one byte
    send_item(OP_FLUSH,  8'h00, 32'h0, 6'd0);           // nothing pending
    send_item(OP_UNUSED, 8'hC3, 32'h1234_5678, 6'd17);
    send_item(OP_ENCODE, 8'h03, 32'h0, 6'd0);           // byte fills exactly
    send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);           // four full bytes
    send_item(OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h02, 32'h0, 6'd0);
    send_item(OP_FLUSH,  8'h00, 32'h0, 6'd0);           // seven pad bits
    send_item(OP_ENCODE, 8'h55, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h00, 32'h0, 6'd0);           // 35 bits in play
    send_item(OP_ENCODE, 8'hAA, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h01, 32'h0, 6'd0);
    send_item(OP_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'd63);  // one pad bit
    send_item(OP_ENCODE, 8'h03, 32'h0, 6'd0);
    send_item(OP_ENCODE, 8'h55, 32'h0, 6'd0);
    send_item(OP_FLUSH,  8'h00, 32'h0, 6'd0);

    // Random phases: free flow, idle source, stalling sink, both lightly
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 79; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 79; end
        default: begin src_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      // long sink hold-off while the source keeps pushing
      if (ph == 0) hold_requests++;
      for (j = 0; j < RANDOM_ITEMS; j++) send_random_item();
    end
    s_axis_tvalid <= 1'b0;

    while (backlog != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d loads, %0d encodes, %0d flushes and %0d unused-opcode items;",
             op_counts[OP_LOAD], op_counts[OP_ENCODE], op_counts[OP_FLUSH],
             op_counts[OP_UNUSED]);
    $display("%0d output bytes compared over four stall patterns and one long sink hold.",
             bytes_checked);
    if (mismatches == 0) begin
      $display("PASS huffman_code_bit_packer");
    end else begin
      $display("FAIL huffman_code_bit_packer");
    end
    $finish;
  end

endmodule

// File: huffman_code_bit_packer.f
+incdir+src
src/hcbp_pkg.sv
src/hcbp_ram.sv
src/hcbp_front.sv
src/hcbp_fifo.sv
src/hcbp_back.sv
src/huffman_code_bit_packer.sv
src/hcbp_checker.sv
tb/sv/hcbp_checker.sv
tb/sv/tb.sv
